// ===== hdl/itp_pkg.sv =====
package itp_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// character and bus widths
	localparam int CHAR_W = 8;
	localparam int USER_W = 8;

	// ascii characters the converter reacts to
	localparam logic [CHAR_W-1:0] CH_LPAR = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR = 8'h29;
	localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7A;

	// stacked operator codes
	typedef enum logic [2:0] {
		OP_LPAR = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	// what an input character asks for
	typedef enum logic [2:0] {
		K_NONE,
		K_LETTER,
		K_LPAR,
		K_RPAR,
		K_OP
	} chr_kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_FINISH
	} itp_state_t;

	// commands to the operator stack
	typedef struct packed {
		logic     fetch;
		logic     push;
		logic     pop;
		logic     clear;
		op_code_t code;
	} stk_cmd_t;

	// status from the operator stack
	typedef struct packed {
		logic     empty;
		logic     full;
		logic     ovf;
		op_code_t top;
	} stk_stat_t;

	function automatic chr_kind_t char_kind(input logic [CHAR_W-1:0] c);
		chr_kind_t k;
		k = K_NONE;
		if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z))
			k = K_LETTER;
		else if (c == CH_LPAR)
			k = K_LPAR;
		else if (c == CH_RPAR)
			k = K_RPAR;
		else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV)
			k = K_OP;
		return k;
	endfunction

	function automatic op_code_t char_code(input logic [CHAR_W-1:0] c);
		op_code_t o;
		case (c)
			CH_ADD:  o = OP_ADD;
			CH_SUB:  o = OP_SUB;
			CH_MUL:  o = OP_MUL;
			CH_DIV:  o = OP_DIV;
			default: o = OP_LPAR;
		endcase
		return o;
	endfunction

	function automatic logic [CHAR_W-1:0] code_char(input op_code_t o);
		logic [CHAR_W-1:0] c;
		case (o)
			OP_LPAR: c = CH_LPAR;
			OP_ADD:  c = CH_ADD;
			OP_SUB:  c = CH_SUB;
			OP_MUL:  c = CH_MUL;
			OP_DIV:  c = CH_DIV;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic op_rank(input op_code_t o);
		return (o == OP_MUL) || (o == OP_DIV);
	endfunction

endpackage

// ===== hdl/itp_stack.sv =====
module itp_stack #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  itp_pkg::stk_cmd_t  cmd,
	output itp_pkg::stk_stat_t stat
);
	import itp_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);
	localparam logic [PW-1:0] ONE_P   = PW'(1);

	op_code_t        mem [STACK_DEPTH];
	op_code_t        top_q;
	logic [PW-1:0]   ptr_q;
	logic            ovf_q;
	logic            empty;
	logic            full;
	logic [PW-1:0]   ptr_m1;

	assign empty  = (ptr_q == '0);
	assign full   = (ptr_q == DEPTH_P);
	assign ptr_m1 = ptr_q - ONE_P;

	// memory write on push, registered read of the top entry on fetch
	always_ff @(posedge clk) begin
		if (cmd.push && !full)
			mem[ptr_q[AW-1:0]] <= cmd.code;
		if (cmd.fetch)
			top_q <= mem[ptr_m1[AW-1:0]];
	end

	// stack pointer and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			ptr_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.push) begin
			if (full)
				ovf_q <= 1'b1;
			else
				ptr_q <= ptr_q + ONE_P;
		end else if (cmd.pop && !empty) begin
			ptr_q <= ptr_m1;
		end
	end

	assign stat.empty = empty;
	assign stat.full  = full;
	assign stat.ovf   = ovf_q;
	assign stat.top   = top_q;

	// checks on the stack bookkeeping
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= DEPTH_P) else $error("stack pointer beyond depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && full && !cmd.clear) |=> (ovf_q && full))
		else $error("push on full stack not flagged");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (empty && !ovf_q)) else $error("clear left stack state");

endmodule

// ===== hdl/infix_to_postfix_converter_core.sv =====
// channel   dir  request fields (low bit up)
// s_axis    in   tdata: in_char[7:0]; tlast: expr_last
// m_axis    out  tdata: out_char[7:0]; tlast: run_last;
//                tuser: char_valid, expr_end, stack_overflow, zero fill
//
// an item is taken only in idle; each item then passes fetch (stack read), eval
// (decide) and finish, and each operator popped repeats fetch then eval, as the
// stack memory has a registered read port; the end flush repeats them per entry.
// arst_n clears sequencer, stack pointer and overflow flag; memory is not cleared.
// a stalled m_axis holds the sequencer wherever a result must leave.
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [itp_pkg::CHAR_W-1:0]  s_axis_tdata,   // in_char
	input  logic                        s_axis_tlast,   // expr_last
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [itp_pkg::CHAR_W-1:0]  m_axis_tdata,   // out_char
	output logic                        m_axis_tlast,   // run_last
	output logic [itp_pkg::USER_W-1:0]  m_axis_tuser    // char_valid, expr_end, stack_overflow
);
	import itp_pkg::*;

	itp_state_t        state_q, state_d;
	chr_kind_t         kind_q, kind_d;
	op_code_t          code_q, code_d;
	logic              last_q, last_d;
	logic              flush_q, flush_d;
	logic              pend_valid_q, pend_valid_d;
	logic [CHAR_W-1:0] pend_char_q, pend_char_d;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_cv_q, out_rl_q, out_end_q, out_ovf_q;
	logic              load_out;
	logic [CHAR_W-1:0] ld_char;
	logic              ld_cv, ld_rl, ld_end, ld_ovf;
	logic              slot_free;
	logic              pop_cond;

	stk_cmd_t          cmd;
	stk_stat_t         st;

	itp_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (st)
	);

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// does the current top entry leave the stack
	always_comb begin
		pop_cond = 1'b0;
		if (!st.empty) begin
			if (flush_q)
				pop_cond = 1'b1;
			else if (kind_q == K_RPAR)
				pop_cond = (st.top != OP_LPAR);
			else if (kind_q == K_OP)
				pop_cond = (st.top != OP_LPAR) && (op_rank(st.top) >= op_rank(code_q));
		end
	end

	// state register and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= K_NONE;
			code_q       <= OP_LPAR;
			last_q       <= 1'b0;
			flush_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			kind_q       <= kind_d;
			code_q       <= code_d;
			last_q       <= last_d;
			flush_q      <= flush_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_char_q <= pend_char_d;
	end

	// sequencer: next state, stack commands and result loads
	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		code_d       = code_q;
		last_d       = last_q;
		flush_d      = flush_q;
		pend_valid_d = pend_valid_q;
		pend_char_d  = pend_char_q;
		cmd          = '{fetch: 1'b0, push: 1'b0, pop: 1'b0, clear: 1'b0, code: code_q};
		load_out     = 1'b0;
		ld_char      = pend_char_q;
		ld_cv        = 1'b1;
		ld_rl        = 1'b0;
		ld_end       = 1'b0;
		ld_ovf       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					kind_d = char_kind(s_axis_tdata);
					code_d = (char_kind(s_axis_tdata) == K_LPAR) ? OP_LPAR
						: char_code(s_axis_tdata);
					last_d = s_axis_tlast;
					if (char_kind(s_axis_tdata) == K_LETTER) begin
						pend_valid_d = 1'b1;
						pend_char_d  = s_axis_tdata;
					end
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_EVAL;
			end
			ST_EVAL: begin
				if (pop_cond) begin
					// pop the top entry into the held slot and emit the previously held one
					if (!pend_valid_q || slot_free) begin
						load_out     = pend_valid_q;
						pend_valid_d = 1'b1;
						pend_char_d  = code_char(st.top);
						cmd.pop      = 1'b1;
						state_d      = ST_FETCH;
					end
				end else if (flush_q) begin
					state_d = ST_FINISH;
				end else begin
					// bracket drop or operator push closes the character's phase
					if (kind_q == K_RPAR)
						cmd.pop = 1'b1;
					if (kind_q == K_LPAR || kind_q == K_OP)
						cmd.push = 1'b1;
					if (last_q) begin
						flush_d = 1'b1;
						state_d = ST_FETCH;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					load_out     = pend_valid_q || last_q;
					ld_char      = pend_valid_q ? pend_char_q : '0;
					ld_cv        = pend_valid_q;
					ld_rl        = 1'b1;
					ld_end       = last_q;
					ld_ovf       = last_q && st.ovf;
					cmd.clear    = last_q;
					pend_valid_d = 1'b0;
					flush_d      = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= ld_char;
			out_cv_q   <= ld_cv;
			out_rl_q   <= ld_rl;
			out_end_q  <= ld_end;
			out_ovf_q  <= ld_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_rl_q;
	assign m_axis_tuser  = {{(USER_W - 3){1'b0}}, out_ovf_q, out_end_q, out_cv_q};

	// checks on the sequencer and result register
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!pend_valid_q && !flush_q))
		else $error("held result or flush left over in idle");
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && slot_free && last_q) |=> (st.empty && !st.ovf))
		else $error("stack not cleared after expression end");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_end_q) |-> out_rl_q)
		else $error("expression end without run end");
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_cv_q) |-> (out_char_q == '0 && out_end_q))
		else $error("empty result malformed");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> slot_free) else $error("result register overwritten");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import itp_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int GOAL = 220;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 4 * DEPTH + 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              char_valid;
		logic              run_last;
		logic              expr_end;
		logic              stack_overflow;
	} postfix_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [CHAR_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic [USER_W-1:0] m_axis_tuser;

	// characters waiting to go out, and postfix results still owed
	in_item_t          char_q[$];
	in_item_t          cur_item;
	postfix_t          postfix_q[$];
	logic [CHAR_W-1:0] expr_buf[$];

	// shadow of the operator stack
	op_code_t          opstk[DEPTH];
	int                opstk_cnt = 0;
	logic              ovf_flag = 1'b0;

	int                send_idle = 8;
	int                recv_idle = 62;
	int                live_cnt = 0;
	int                n_chars = 0;
	int                n_results = 0;
	int                n_exprs = 0;
	int                ovf_ends = 0;
	int                err_cnt = 0;
	int                hold_cnt = 0;
	logic              long_hold_done = 1'b0;
	int                quiet_cycles = 0;
	postfix_t          got_res;
	postfix_t          want_res;
	logic [USER_W-1:0] want_user;

	infix_to_postfix_converter_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // in_char
		.s_axis_tlast  (s_axis_tlast),   // expr_last
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // out_char
		.m_axis_tlast  (m_axis_tlast),   // run_last
		.m_axis_tuser  (m_axis_tuser)    // char_valid, expr_end, stack_overflow, zero fill
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function automatic logic is_live(input logic [CHAR_W-1:0] c, input logic last);
		return last || is_letter(c) || c == CH_LPAR || c == CH_RPAR ||
			c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV;
	endfunction

	function automatic logic [CHAR_W-1:0] glyph_of(input op_code_t o);
		logic [CHAR_W-1:0] g;
		case (o)
			OP_ADD:  g = CH_ADD;
			OP_SUB:  g = CH_SUB;
			OP_MUL:  g = CH_MUL;
			OP_DIV:  g = CH_DIV;
			default: g = CH_LPAR;
		endcase
		return g;
	endfunction

	function automatic logic binds_tight(input op_code_t o);
		return o == OP_MUL || o == OP_DIV;
	endfunction

	function automatic postfix_t mk_res(input logic [CHAR_W-1:0] c, input logic v);
		postfix_t r;
		r.out_char = c;
		r.char_valid = v;
		r.run_last = 1'b0;
		r.expr_end = 1'b0;
		r.stack_overflow = 1'b0;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_letter();
		logic [CHAR_W-1:0] base;
		base = $urandom_range(1) ? CH_UC_A : CH_LC_A;
		return base + CHAR_W'($urandom_range(25));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_op();
		logic [CHAR_W-1:0] g;
		case ($urandom_range(3))
			0:       g = CH_ADD;
			1:       g = CH_SUB;
			2:       g = CH_MUL;
			default: g = CH_DIV;
		endcase
		return g;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_token();
		logic [CHAR_W-1:0] g;
		case ($urandom_range(2))
			0:       g = CH_LPAR;
			1:       g = CH_RPAR;
			default: g = rand_op();
		endcase
		return g;
	endfunction

	task automatic push_op(input op_code_t code);
		if (opstk_cnt >= DEPTH) begin
			ovf_flag = 1'b1;
		end else begin
			opstk[opstk_cnt] = code;
			opstk_cnt++;
		end
	endtask

	// shunting-yard step: expected results for one accepted character
	task automatic shunt_char(input logic [CHAR_W-1:0] c, input logic last);
		postfix_t run[$];
		postfix_t r;
		op_code_t code;
		logic     is_op;
		is_op = 1'b1;
		code = OP_LPAR;
		case (c)
			CH_ADD:  code = OP_ADD;
			CH_SUB:  code = OP_SUB;
			CH_MUL:  code = OP_MUL;
			CH_DIV:  code = OP_DIV;
			default: is_op = 1'b0;
		endcase
		if (is_letter(c)) begin
			run.insert(run.size(), mk_res(c, 1'b1));
		end else if (c == CH_RPAR) begin
			// pop to the matching bracket; an unmatched one empties the stack
			while (opstk_cnt > 0 && opstk[opstk_cnt-1] != OP_LPAR) begin
				run.insert(run.size(), mk_res(glyph_of(opstk[opstk_cnt-1]), 1'b1));
				opstk_cnt--;
			end
			if (opstk_cnt > 0)
				opstk_cnt--;
		end else if (c == CH_LPAR) begin
			push_op(OP_LPAR);
		end else if (is_op) begin
			// pop equal or higher priority, stopping at a bracket
			while (opstk_cnt > 0 && opstk[opstk_cnt-1] != OP_LPAR &&
				binds_tight(opstk[opstk_cnt-1]) >= binds_tight(code)) begin
				run.insert(run.size(), mk_res(glyph_of(opstk[opstk_cnt-1]), 1'b1));
				opstk_cnt--;
			end
			push_op(code);
		end
		if (last) begin
			// end of expression: flush everything, brackets included
			while (opstk_cnt > 0) begin
				run.insert(run.size(), mk_res(glyph_of(opstk[opstk_cnt-1]), 1'b1));
				opstk_cnt--;
			end
			if (run.size() == 0)
				run.insert(0, mk_res('0, 1'b0));
			r = run[run.size() - 1];
			r.expr_end = 1'b1;
			r.stack_overflow = ovf_flag;
			run[run.size() - 1] = r;
			if (ovf_flag)
				ovf_ends++;
			n_exprs++;
			opstk_cnt = 0;
			ovf_flag = 1'b0;
		end
		if (run.size() > 0) begin
			r = run[run.size() - 1];
			r.run_last = 1'b1;
			run[run.size() - 1] = r;
		end
		foreach (run[i])
			postfix_q.insert(postfix_q.size(), run[i]);
	endtask

	task automatic add_item(input logic [CHAR_W-1:0] c, input logic last);
		in_item_t it;
		it.ch = c;
		it.last = last;
		char_q.insert(char_q.size(), it);
		if (is_live(c, last))
			live_cnt++;
	endtask

	task automatic push_expr();
		foreach (expr_buf[i])
			add_item(expr_buf[i], i == expr_buf.size() - 1);
	endtask

	// balanced expression with random letters, operators and nesting, plus the odd random byte
	task automatic gen_formed();
		int target;
		int depth;
		logic want_term;
		expr_buf = {};
		target = $urandom_range(12, 1);
		depth = 0;
		want_term = 1'b1;
		while (1) begin
			if ($urandom_range(24) == 0)
				expr_buf.insert(expr_buf.size(), CHAR_W'($urandom_range(255)));
			if (want_term) begin
				if (depth < 5 && $urandom_range(3) == 0) begin
					expr_buf.insert(expr_buf.size(), CH_LPAR);
					depth++;
				end else begin
					expr_buf.insert(expr_buf.size(), rand_letter());
					want_term = 1'b0;
				end
			end else if (depth > 0 && $urandom_range(2) == 0) begin
				expr_buf.insert(expr_buf.size(), CH_RPAR);
				depth--;
			end else if (expr_buf.size() >= target) begin
				if (depth == 0)
					break;
				expr_buf.insert(expr_buf.size(), CH_RPAR);
				depth--;
			end else begin
				expr_buf.insert(expr_buf.size(), rand_op());
				want_term = 1'b1;
			end
		end
	endtask

	// deep nesting to run the stack into its limit
	task automatic gen_deep(input int n, input int op_pct);
		expr_buf = {};
		for (int i = 0; i < n; i++) begin
			expr_buf.insert(expr_buf.size(), CH_LPAR);
			if ($urandom_range(99) < op_pct) begin
				expr_buf.insert(expr_buf.size(), rand_letter());
				expr_buf.insert(expr_buf.size(), rand_op());
			end
		end
		expr_buf.insert(expr_buf.size(), rand_letter());
		push_expr();
	endtask

	task automatic gen_random(input int goal);
		int pick;
		int pos;
		int n;
		while (live_cnt < goal) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				gen_formed();
				push_expr();
			end else if (pick < 90) begin
				// broken expression: replaced, dropped or stray tokens
				gen_formed();
				n = $urandom_range(3, 1);
				for (int k = 0; k < n; k++) begin
					pos = $urandom_range(expr_buf.size() - 1);
					case ($urandom_range(2))
						0: expr_buf[pos] = rand_token();
						1: if (expr_buf.size() > 1) expr_buf.delete(pos);
						default: expr_buf.insert(expr_buf.size(), rand_token());
					endcase
				end
				push_expr();
			end else begin
				// raw byte noise
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++)
					add_item(CHAR_W'($urandom_range(255)),
						k == n - 1 && $urandom_range(2) == 0);
			end
		end
	endtask

	task automatic note_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	// wait until everything sent has been converted and collected
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (char_q.size() > 0 || s_axis_tvalid || postfix_q.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				shunt_char(cur_item.ch, cur_item.last);
				n_chars++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (char_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_item = char_q[0];
					char_q.delete(0);
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cur_item.ch;
					s_axis_tlast <= cur_item.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && n_results >= 40) begin
			hold_cnt <= LONG_HOLD;
			long_hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			got_res.out_char = m_axis_tdata;
			got_res.char_valid = m_axis_tuser[0];
			got_res.run_last = m_axis_tlast;
			got_res.expr_end = m_axis_tuser[1];
			got_res.stack_overflow = m_axis_tuser[2];
			if (postfix_q.size() == 0) begin
				note_mismatch($sformatf(
					"unexpected result at %0t: char %h tlast %b tuser %h",
					$realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser));
			end else begin
				want_res = postfix_q[0];
				postfix_q.delete(0);
				want_user = '0;
				want_user[0] = want_res.char_valid;
				want_user[1] = want_res.expr_end;
				want_user[2] = want_res.stack_overflow;
				if (m_axis_tdata !== want_res.out_char ||
					m_axis_tlast !== want_res.run_last ||
					m_axis_tuser !== want_user)
					note_mismatch($sformatf({
						"bad result at %0t: got char %h valid %b last %b end %b ",
						"ovf %b (tuser %h), wanted char %h valid %b last %b end %b ",
						"ovf %b"},
						$realtime, got_res.out_char, got_res.char_valid,
						got_res.run_last, got_res.expr_end, got_res.stack_overflow,
						m_axis_tuser, want_res.out_char, want_res.char_valid,
						want_res.run_last, want_res.expr_end,
						want_res.stack_overflow));
			end
		end
	end

	// watchdog on cycles with no request moving either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("infix_to_postfix_converter_core: mismatch");
				$finish;
			end
		end
	end

	// stimulus and phase control
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: letter bounds, neighbouring bytes, every operator,
		// unmatched close, matched brackets, open bracket flushed, empty end
		add_item(CH_UC_A, 1'b0);
		add_item(CH_UC_Z, 1'b0);
		add_item(CH_LC_A, 1'b0);
		add_item(CH_LC_Z, 1'b0);
		add_item(CH_UC_A - 8'd1, 1'b0);
		add_item(CH_UC_Z + 8'd1, 1'b0);
		add_item(CH_LC_A - 8'd1, 1'b0);
		add_item(CH_LC_Z + 8'd1, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(CH_ADD, 1'b0);
		add_item(CH_LC_A + 8'd1, 1'b0);
		add_item(CH_MUL, 1'b0);
		add_item(CH_LC_A + 8'd2, 1'b0);
		add_item(CH_SUB, 1'b0);
		add_item(CH_DIV, 1'b0);
		add_item(CH_LC_A + 8'd3, 1'b0);
		add_item(CH_RPAR, 1'b0);
		add_item(CH_LPAR, 1'b0);
		add_item(CH_LC_A + 8'd4, 1'b0);
		add_item(CH_RPAR, 1'b0);
		add_item(CH_LPAR, 1'b1);
		add_item(CH_RPAR, 1'b1);
		add_item(CH_ADD, 1'b0);
		add_item(8'h7F, 1'b1);

		// full stack: brackets only, then mixed with operators
		gen_deep(DEPTH + 4, 0);
		gen_random(80);
		drain();

		send_idle = 62;
		recv_idle = 8;
		gen_deep($urandom_range(DEPTH + 8, DEPTH / 2), 40);
		gen_random(150);
		drain();

		send_idle = 0;
		recv_idle = 0;
		gen_deep($urandom_range(DEPTH + 8, DEPTH - 2), 25);
		gen_random(GOAL);
		drain();

		if (postfix_q.size() > 0)
			note_mismatch($sformatf("%0d results never arrived", postfix_q.size()));
		$display("run: %0d characters in %0d expressions, %0d postfix results checked",
			n_chars, n_exprs, n_results);
		$display("run: %0d expressions ended with a dropped push, %0d errors",
			ovf_ends, err_cnt);
		if (err_cnt == 0) begin
			$display("infix_to_postfix_converter_core: match");
		end else begin
			$display("infix_to_postfix_converter_core: mismatch");
		end
		$finish;
	end

endmodule
